FILE: sv/sta_pkg.sv
// sta_pkg: shared types and codes of the slot table allocator
// request kinds, result status codes and the controller/datapath interface structs
// no dependencies
package sta_pkg;

    // request kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_SEARCH = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BOUNDS = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_ZERO   = 3'd4;

    // field widths
    localparam int TYPE_W   = 2;
    localparam int KEY_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int RKEY_W   = 4;
    localparam int STATUS_W = 3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch a new request, rewind the scan
        logic key_rd;     // read the slot at the request key
        logic scan_rd;    // read the slot at the scan index and step it
        logic scan_drain; // scan over, drop the pending compare
        logic finish;     // form the result, do the table update
    } sta_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       zero_val;  // insert value is zero
        logic       key_oob;   // key beyond the table
        logic       hit;       // compared slot matches the scan target
        logic       scan_end;  // scan index past the last slot
    } sta_stat_t;

endpackage

FILE: sv/sta_datapath.sv
// sta_datapath: request registers, slot memory with valid bits, scan index and result registers
// depends on sta_pkg; driven by sta_ctrl through sta_cmd_t
module sta_datapath
    import sta_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int FIRST_SLOT  = 2,
    parameter int VALUE_BITS  = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sta_cmd_t            cmd,
    output sta_stat_t           stat,
    input  logic [TYPE_W-1:0]   req_type,
    input  logic [KEY_W-1:0]    req_key,
    input  logic [VALUE_W-1:0]  req_value,
    output logic [RKEY_W-1:0]   result_key,
    output logic [VALUE_W-1:0]  result_value,
    output logic [STATUS_W-1:0] status
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int SPAN  = (TABLE_SLOTS > FIRST_SLOT) ? TABLE_SLOTS : FIRST_SLOT;
    localparam int CNT_W = $clog2(SPAN + 1);

    // request registers
    logic [TYPE_W-1:0]     type_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // slot memory and per-slot valid bits
    logic [VALUE_BITS-1:0]  mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] vld_reg;
    logic [TABLE_SLOTS-1:0] vld_next;

    // read port and scan state
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic                  rd_live_reg;
    logic                  rd_live_next;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    // result registers
    logic [RKEY_W-1:0]   res_key_reg;
    logic [VALUE_W-1:0]  res_val_reg;
    logic [STATUS_W-1:0] res_st_reg;
    logic [RKEY_W-1:0]   res_key_next;
    logic [VALUE_W-1:0]  res_val_next;
    logic [STATUS_W-1:0] res_st_next;

    logic [VALUE_BITS-1:0] entry;
    logic [VALUE_BITS-1:0] target;
    logic                  match;
    logic                  key_oob;
    logic                  zero_val;
    logic                  mem_we;
    logic                  slot_free;

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= req_type;
            key_reg  <= req_key;
            val_reg  <= VALUE_BITS'(req_value);
        end
    end

    // compare side
    assign entry    = rd_vld_reg ? rd_data_reg : '0;
    assign target   = (type_reg == REQ_INSERT) ? '0 : val_reg;
    assign match    = (entry == target);
    assign key_oob  = ({1'b0, key_reg} >= (KEY_W+1)'(TABLE_SLOTS));
    assign zero_val = (val_reg == '0);

    assign stat.req_type = type_reg;
    assign stat.zero_val = zero_val;
    assign stat.key_oob  = key_oob;
    assign stat.hit      = rd_live_reg && match;
    assign stat.scan_end = (idx_reg >= CNT_W'(TABLE_SLOTS));

    // read address select
    assign rd_en   = cmd.key_rd || cmd.scan_rd;
    assign rd_addr = cmd.key_rd ? key_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    // scan index and compare tracking
    always_comb
    begin
        idx_next     = idx_reg;
        rd_live_next = rd_live_reg;
        if (cmd.load)
        begin
            idx_next     = CNT_W'(FIRST_SLOT);
            rd_live_next = 1'b0;
        end
        else if (rd_en)
        begin
            rd_live_next = 1'b1;
            if (cmd.scan_rd)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (cmd.scan_drain)
        begin
            rd_live_next = 1'b0;
        end
    end

    // result and table update
    assign mem_we    = cmd.finish && (type_reg == REQ_INSERT) && !zero_val && stat.hit;
    assign slot_free = cmd.finish && (type_reg == REQ_REMOVE) && !key_oob
                       && rd_live_reg && (entry != '0);

    always_comb
    begin
        res_key_next = res_key_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        vld_next     = vld_reg;
        if (cmd.finish)
        begin
            res_key_next = '0;
            res_val_next = '0;
            res_st_next  = ST_OK;
            unique case (type_reg)
                REQ_INSERT:
                begin
                    if (zero_val)
                    begin
                        res_st_next = ST_ZERO;
                    end
                    else if (stat.hit)
                    begin
                        res_key_next = RKEY_W'(cmp_idx_reg);
                    end
                    else
                    begin
                        res_st_next = ST_FULL;
                    end
                end
                REQ_FIND, REQ_REMOVE:
                begin
                    if (key_oob)
                    begin
                        res_st_next = ST_BOUNDS;
                    end
                    else
                    begin
                        res_val_next = VALUE_W'(entry);
                        if (entry == '0)
                        begin
                            res_st_next = ST_EMPTY;
                        end
                    end
                end
                REQ_SEARCH:
                begin
                    if (stat.hit)
                    begin
                        res_key_next = RKEY_W'(cmp_idx_reg);
                    end
                    else
                    begin
                        res_st_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    res_st_next = ST_EMPTY;
                end
            endcase
        end
        if (mem_we)
        begin
            vld_next[cmp_idx_reg] = 1'b1;
        end
        if (slot_free)
        begin
            vld_next[key_reg[IDX_W-1:0]] = 1'b0;
        end
    end

    // slot memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmp_idx_reg] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
        if (cmd.scan_rd)
        begin
            cmp_idx_reg <= idx_reg[IDX_W-1:0];
        end
        res_key_reg <= res_key_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
    end

    // control state: valid bits, scan index, compare flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            idx_reg     <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            idx_reg     <= idx_next;
            rd_live_reg <= rd_live_next;
        end
    end

    assign result_key   = res_key_reg;
    assign result_value = res_val_reg;
    assign status       = res_st_reg;

    // an insert only ever lands in a free slot
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !vld_reg[cmp_idx_reg])
        else $error("insert writes over an occupied slot");

    // a scan hit never points below the first usable slot
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.hit && (type_reg == REQ_INSERT || type_reg == REQ_SEARCH))
            |-> (CNT_W'(cmp_idx_reg) >= CNT_W'(FIRST_SLOT)))
        else $error("scan hit below the first usable slot");

    // a freed slot reads as free afterwards
    a_free_done: assert property (@(posedge clk) disable iff (!rst_n)
        slot_free |=> !vld_reg[$past(key_reg[IDX_W-1:0])])
        else $error("remove did not free the slot");

endmodule

FILE: sv/sta_ctrl.sv
// sta_ctrl: request sequencing for the slot table allocator
// depends on sta_pkg; commands sta_datapath and owns the input ready and output valid
module sta_ctrl
    import sta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output sta_cmd_t  cmd,
    input  sta_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.req_type == REQ_FIND || stat.req_type == REQ_REMOVE)
                begin
                    cmd.key_rd = !stat.key_oob;
                    state_next = S_FINISH;
                end
                else if (stat.req_type == REQ_INSERT && stat.zero_val)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_rd = !stat.scan_end;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.scan_end)
                begin
                    cmd.scan_drain = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result is never formed over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while stalled");

    // every finished request is offered downstream
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");

    // the scan stops reading once it has a hit
    a_stop_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && stat.hit) |-> !cmd.scan_rd)
        else $error("scan continued past a hit");

endmodule

FILE: sv/slot_table_allocator.sv
// slot_table_allocator: top level of the slot table allocator
// Usage:
//   A table of TABLE_SLOTS value slots; a slot that holds zero is free.
//   Requests enter on the s_ channel: s_tuser carries the request kind
//   (insert, find, remove, search by value), s_tdata the key and the value.
//   Each request yields exactly one result on the m_ channel: m_tdata holds
//   the slot key and the value read, m_tuser the status code.
//   One request is worked on at a time. Find, remove (also with a key out of
//   bounds) and inserts of zero go from the check step straight to the final
//   step, which sets m_tvalid. Insert and search scan the slot memory from
//   FIRST_SLOT upward, one slot per cycle through its single registered read
//   port, and stop at the first hit or past the last slot for the final step.
//   The next request is accepted in the cycle after a result is formed.
//   s_tready is high whenever no request is in progress, also while a result
//   waits in the output register; when the receiver stalls, the next request
//   waits in its final step until the output register drains.
//   Reset clears the per-slot valid bits at once, so all slots read as free
//   from the first cycle after reset; no clearing pass is needed.
// Depends on sta_pkg, sta_ctrl and sta_datapath.
module slot_table_allocator
    import sta_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int FIRST_SLOT  = 2,
    parameter int VALUE_BITS  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // req_key [7:0], req_value [39:8]
    input  logic [1:0]  s_tuser,  // req_type [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // result_key [3:0], result_value [35:4], zero [39:36]
    output logic [2:0]  m_tuser   // status [2:0]
);

    sta_cmd_t            cmd;
    sta_stat_t           stat;
    logic [RKEY_W-1:0]   result_key;
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;

    // request sequencing
    sta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // table storage and result forming
    sta_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .FIRST_SLOT  (FIRST_SLOT),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (s_tuser),
        .req_key      (s_tdata[7:0]),
        .req_value    (s_tdata[39:8]),
        .result_key   (result_key),
        .result_value (result_value),
        .status       (status)
    );

    // output packing
    assign m_tdata = {4'b0000, result_value, result_key};
    assign m_tuser = status;

endmodule
